@@ hdl/fes_pkg.sv @@
// ----------------------------------------------------------------------------
// fes_pkg
// Shared types, register codes, reset values and timing constants for the
// flight event sequencer.
// ----------------------------------------------------------------------------
package fes_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned AccW   = 19;
  localparam int unsigned SpdW   = 19;
  localparam int unsigned HgtW   = 27;
  localparam int unsigned LimW   = 18;
  localparam int unsigned HLimW  = 26;
  localparam int unsigned SqW    = 37;
  localparam int unsigned SumW   = 38;
  localparam int unsigned LsqW   = 36;
  localparam int unsigned EvW    = 9;
  localparam int unsigned FlagW  = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // flag and event bit positions
  localparam int unsigned FLG_LAUNCH  = 0;
  localparam int unsigned FLG_BURNOUT = 1;
  localparam int unsigned FLG_APOGEE  = 2;
  localparam int unsigned FLG_DROGUE  = 3;
  localparam int unsigned FLG_MAIN    = 4;
  localparam int unsigned FLG_LANDED  = 5;
  localparam int unsigned FLG_DSEEN   = 6;
  localparam int unsigned FLG_MSEEN   = 7;
  localparam int unsigned EV_LIMIT    = 8;

  localparam logic [TimeW-1:0] BURNOUT_HOLD_MS = 32'd500;
  localparam logic [TimeW-1:0] APOGEE_HOLD_MS  = 32'd200;
  localparam logic [TimeW-1:0] DROGUE_DELAY_MS = 32'd5000;
  localparam logic signed [SpdW-1:0] LANDED_SPEED = 19'sd50;

  localparam logic [LimW-1:0]  RST_LAUNCH_ACCEL  = 18'd9810;
  localparam logic [LimW-1:0]  RST_BURNOUT_ACCEL = 18'd4905;
  localparam logic [LimW-1:0]  RST_DROGUE_SPIKE  = 18'd4905;
  localparam logic [LimW-1:0]  RST_MAIN_SPIKE    = 18'd2943;
  localparam logic [HLimW-1:0] RST_MIN_APOGEE    = 26'd10000;
  localparam logic [HLimW-1:0] RST_MAIN_FIRE     = 26'd100000;
  localparam logic [HLimW-1:0] RST_LIMIT_HEIGHT  = 26'd1200000;
  localparam logic [LimW-1:0]  RST_LIMIT_SPEED   = 18'd51000;

  typedef enum logic [2:0] {
    REG_LAUNCH_ACCEL  = 3'd0,
    REG_BURNOUT_ACCEL = 3'd1,
    REG_DROGUE_SPIKE  = 3'd2,
    REG_MAIN_SPIKE    = 3'd3,
    REG_MIN_APOGEE    = 3'd4,
    REG_MAIN_FIRE     = 3'd5,
    REG_LIMIT_HEIGHT  = 3'd6,
    REG_LIMIT_SPEED   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LimW-1:0]  launch_accel_limit;
    logic [LimW-1:0]  burnout_accel_limit;
    logic [LimW-1:0]  drogue_spike_limit;
    logic [LimW-1:0]  main_spike_limit;
    logic [HLimW-1:0] min_apogee_height;
    logic [HLimW-1:0] main_fire_height;
    logic [HLimW-1:0] limit_height;
    logic [LimW-1:0]  limit_speed;
  } fes_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]        time_ms;
    logic signed [AccW-1:0]  vert_accel;
    logic signed [SpdW-1:0]  east_speed;
    logic signed [SpdW-1:0]  north_speed;
    logic signed [SpdW-1:0]  up_speed;
    logic signed [HgtW-1:0]  height;
    logic signed [HgtW-1:0]  site_height;
  } fes_sample_t;

  typedef struct packed {
    logic [SqW-1:0] sq_east;
    logic [SqW-1:0] sq_north;
    logic [SqW-1:0] sq_up;
  } fes_sq_t;

endpackage

@@ hdl/flight_event_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// flight_event_sequencer_top
// Three-stage pipeline: input register, speed squares, flight checks into
// the result register; thresholds through an APB register file.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_*): one navigation sample per word, taken at an edge
//   with in_valid high and in_stall low. Result channel (out_*): one word per
//   sample with the events raised in that step and the latched flags after it.
//   An accepted sample reaches out_* through the squares and result registers.
//   Throughput: one sample per cycle while out_stall is low; the flight state
//   is updated as a sample leaves the check stage, so consecutive samples see
//   each other's state.
//   Stalls: each stage holds its word while the one after it is full and
//   stalled; in_stall rises only when all three stages hold words and
//   out_stall is high.
//   Reset (rst_n low at an edge): pipeline emptied, flight state cleared and
//   thresholds back to their default values.
//   Registers are written through psel/penable/pwrite at byte address 4*i;
//   the user must write only while no sample is in flight; the block lacks a check.
// ----------------------------------------------------------------------------
module flight_event_sequencer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fes_pkg::TimeW-1:0]            in_time_ms,
  input  logic signed [fes_pkg::AccW-1:0]      in_vert_accel,
  input  logic signed [fes_pkg::SpdW-1:0]      in_east_speed,
  input  logic signed [fes_pkg::SpdW-1:0]      in_north_speed,
  input  logic signed [fes_pkg::SpdW-1:0]      in_up_speed,
  input  logic signed [fes_pkg::HgtW-1:0]      in_height,
  input  logic signed [fes_pkg::HgtW-1:0]      in_site_height,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [fes_pkg::EvW-1:0]              out_event_mask,
  output logic [fes_pkg::FlagW-1:0]            out_flight_flags,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fes_pkg::AddrW-1:0]            paddr,
  input  logic [fes_pkg::DataW-1:0]            pwdata,
  output logic [fes_pkg::DataW-1:0]            prdata,
  output logic                                 pready
);

  fes_pkg::fes_cfg_t    cfg;
  fes_pkg::fes_sample_t s1_r;
  fes_pkg::fes_sample_t s2_r;
  fes_pkg::fes_sq_t     sq;
  logic [fes_pkg::LsqW-1:0]  limit_sq;
  logic [fes_pkg::EvW-1:0]   events;
  logic [fes_pkg::FlagW-1:0] flags_nxt;

  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s3_free, s2_free, s1_free;
  logic s1_ld, s2_ld, s3_ld;
  logic [fes_pkg::EvW-1:0]   out_event_r;
  logic [fes_pkg::FlagW-1:0] out_flags_r;

  assign s3_free  = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign s1_ld    = in_valid && s1_free;
  assign s2_ld    = s1_valid_r && s2_free;
  assign s3_ld    = s2_valid_r && s3_free;

  fes_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // sample words, no reset needed
  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_r.time_ms     <= in_time_ms;
      s1_r.vert_accel  <= in_vert_accel;
      s1_r.east_speed  <= in_east_speed;
      s1_r.north_speed <= in_north_speed;
      s1_r.up_speed    <= in_up_speed;
      s1_r.height      <= in_height;
      s1_r.site_height <= in_site_height;
    end
    if (s2_ld) begin
      s2_r <= s1_r;
    end
    if (s3_ld) begin
      out_event_r <= events;
      out_flags_r <= flags_nxt;
    end
  end

  fes_speed_sq u_speed_sq (
    .clk         (clk),
    .ld          (s2_ld),
    .east_speed  (s1_r.east_speed),
    .north_speed (s1_r.north_speed),
    .up_speed    (s1_r.up_speed),
    .limit_speed (cfg.limit_speed),
    .sq          (sq),
    .limit_sq    (limit_sq)
  );

  fes_checks u_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (s3_ld),
    .smp       (s2_r),
    .sq        (sq),
    .limit_sq  (limit_sq),
    .cfg       (cfg),
    .events    (events),
    .flags_nxt (flags_nxt)
  );

  assign out_valid        = out_valid_r;
  assign out_event_mask   = out_event_r;
  assign out_flight_flags = out_flags_r;

`ifndef SYNTHESIS
  // every event raised in a step, the limit event aside, has its flag latched in the same word
  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_event_r[fes_pkg::FlagW-1:0] & ~out_flags_r) == '0))
    else $error("event word carries an event without its flag");
`endif

endmodule

@@ hdl/fes_cfg.sv @@
// ----------------------------------------------------------------------------
// fes_cfg
// APB register file holding the thresholds of the flight checks.
// ----------------------------------------------------------------------------
module fes_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fes_pkg::AddrW-1:0]   paddr,
  input  logic [fes_pkg::DataW-1:0]   pwdata,
  output logic [fes_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output fes_pkg::fes_cfg_t           cfg
);

  fes_pkg::fes_cfg_t cfg_r;
  fes_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = fes_pkg::reg_idx_t'(paddr[fes_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.launch_accel_limit  <= fes_pkg::RST_LAUNCH_ACCEL;
      cfg_r.burnout_accel_limit <= fes_pkg::RST_BURNOUT_ACCEL;
      cfg_r.drogue_spike_limit  <= fes_pkg::RST_DROGUE_SPIKE;
      cfg_r.main_spike_limit    <= fes_pkg::RST_MAIN_SPIKE;
      cfg_r.min_apogee_height   <= fes_pkg::RST_MIN_APOGEE;
      cfg_r.main_fire_height    <= fes_pkg::RST_MAIN_FIRE;
      cfg_r.limit_height        <= fes_pkg::RST_LIMIT_HEIGHT;
      cfg_r.limit_speed         <= fes_pkg::RST_LIMIT_SPEED;
    end else if (wr_en) begin
      unique case (idx)
        fes_pkg::REG_LAUNCH_ACCEL:  cfg_r.launch_accel_limit  <= pwdata[fes_pkg::LimW-1:0];
        fes_pkg::REG_BURNOUT_ACCEL: cfg_r.burnout_accel_limit <= pwdata[fes_pkg::LimW-1:0];
        fes_pkg::REG_DROGUE_SPIKE:  cfg_r.drogue_spike_limit  <= pwdata[fes_pkg::LimW-1:0];
        fes_pkg::REG_MAIN_SPIKE:    cfg_r.main_spike_limit    <= pwdata[fes_pkg::LimW-1:0];
        fes_pkg::REG_MIN_APOGEE:    cfg_r.min_apogee_height   <= pwdata[fes_pkg::HLimW-1:0];
        fes_pkg::REG_MAIN_FIRE:     cfg_r.main_fire_height    <= pwdata[fes_pkg::HLimW-1:0];
        fes_pkg::REG_LIMIT_HEIGHT:  cfg_r.limit_height        <= pwdata[fes_pkg::HLimW-1:0];
        fes_pkg::REG_LIMIT_SPEED:   cfg_r.limit_speed         <= pwdata[fes_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      fes_pkg::REG_LAUNCH_ACCEL:  prdata[fes_pkg::LimW-1:0]  = cfg_r.launch_accel_limit;
      fes_pkg::REG_BURNOUT_ACCEL: prdata[fes_pkg::LimW-1:0]  = cfg_r.burnout_accel_limit;
      fes_pkg::REG_DROGUE_SPIKE:  prdata[fes_pkg::LimW-1:0]  = cfg_r.drogue_spike_limit;
      fes_pkg::REG_MAIN_SPIKE:    prdata[fes_pkg::LimW-1:0]  = cfg_r.main_spike_limit;
      fes_pkg::REG_MIN_APOGEE:    prdata[fes_pkg::HLimW-1:0] = cfg_r.min_apogee_height;
      fes_pkg::REG_MAIN_FIRE:     prdata[fes_pkg::HLimW-1:0] = cfg_r.main_fire_height;
      fes_pkg::REG_LIMIT_HEIGHT:  prdata[fes_pkg::HLimW-1:0] = cfg_r.limit_height;
      fes_pkg::REG_LIMIT_SPEED:   prdata[fes_pkg::LimW-1:0]  = cfg_r.limit_speed;
      default: prdata = '0;
    endcase
  end

endmodule

@@ hdl/fes_speed_sq.sv @@
// ----------------------------------------------------------------------------
// fes_speed_sq
// Squares the three velocity components into a pipeline register, and keeps
// the square of the configured speed limit registered.
// ----------------------------------------------------------------------------
module fes_speed_sq (
  input  logic                              clk,
  input  logic                              ld,
  input  logic signed [fes_pkg::SpdW-1:0]   east_speed,
  input  logic signed [fes_pkg::SpdW-1:0]   north_speed,
  input  logic signed [fes_pkg::SpdW-1:0]   up_speed,
  input  logic [fes_pkg::LimW-1:0]          limit_speed,
  output fes_pkg::fes_sq_t                  sq,
  output logic [fes_pkg::LsqW-1:0]          limit_sq
);

  logic signed [fes_pkg::SqW:0]  prod_e;
  logic signed [fes_pkg::SqW:0]  prod_n;
  logic signed [fes_pkg::SqW:0]  prod_u;
  fes_pkg::fes_sq_t              sq_r;
  logic [fes_pkg::LsqW-1:0]      limit_sq_r;
  logic [fes_pkg::LsqW-1:0]      limit_sq_nxt;

  assign prod_e       = east_speed * east_speed;
  assign prod_n       = north_speed * north_speed;
  assign prod_u       = up_speed * up_speed;
  assign limit_sq_nxt = limit_speed * limit_speed;

  // squares are never negative, so the sign bit is dropped
  always_ff @(posedge clk) begin
    if (ld) begin
      sq_r.sq_east  <= prod_e[fes_pkg::SqW-1:0];
      sq_r.sq_north <= prod_n[fes_pkg::SqW-1:0];
      sq_r.sq_up    <= prod_u[fes_pkg::SqW-1:0];
    end
    limit_sq_r <= limit_sq_nxt;
  end

  assign sq       = sq_r;
  assign limit_sq = limit_sq_r;

endmodule

@@ hdl/fes_checks.sv @@
// ----------------------------------------------------------------------------
// fes_checks
// Flight state and the chain of flight checks for one sample, applied in
// order so that each check sees the flags raised earlier in the same step.
// ----------------------------------------------------------------------------
module fes_checks (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ld,
  input  fes_pkg::fes_sample_t          smp,
  input  fes_pkg::fes_sq_t              sq,
  input  logic [fes_pkg::LsqW-1:0]      limit_sq,
  input  fes_pkg::fes_cfg_t             cfg,
  output logic [fes_pkg::EvW-1:0]       events,
  output logic [fes_pkg::FlagW-1:0]     flags_nxt
);

  localparam int unsigned DW = fes_pkg::HgtW + 1;
  localparam int unsigned NW = DW + 5;

  logic [fes_pkg::FlagW-1:0]        flags_r;
  logic                             bt_r, bt_nxt;
  logic [fes_pkg::TimeW-1:0]        bs_r, bs_nxt;
  logic                             dt_r, dt_nxt;
  logic [fes_pkg::TimeW-1:0]        ds_r, ds_nxt;
  logic                             atk_r, atk_nxt;
  logic [fes_pkg::TimeW-1:0]        at_r, at_nxt;
  logic signed [fes_pkg::HgtW-1:0]  lh_r, lh_nxt;

  logic [fes_pkg::FlagW-1:0]        f;
  logic [fes_pkg::EvW-1:0]          ev;
  logic [2:0]                       pre;

  logic acc_gt_launch, acc_lt_burnout, acc_gt_dspike, acc_gt_mspike;
  logic vu_pos, vu_neg, vu_slow;
  logic h_gt_apogee, h_lt_main, h_gt_limit, speed_gt_limit;
  logic burn_hold, desc_hold, drogue_hold;
  logic near;

  logic signed [DW-1:0]       diff;
  logic [DW-1:0]              gap;
  logic [NW-1:0]              gap20;
  logic [fes_pkg::SumW-1:0]   speed_sq;

  // launch, burnout and apogee all set
  assign pre = '1;

  assign acc_gt_launch  = smp.vert_accel > $signed({1'b0, cfg.launch_accel_limit});
  assign acc_lt_burnout = smp.vert_accel < $signed({1'b0, cfg.burnout_accel_limit});
  assign acc_gt_dspike  = smp.vert_accel > $signed({1'b0, cfg.drogue_spike_limit});
  assign acc_gt_mspike  = smp.vert_accel > $signed({1'b0, cfg.main_spike_limit});

  assign vu_neg  = smp.up_speed[fes_pkg::SpdW-1];
  assign vu_pos  = !vu_neg && (smp.up_speed != '0);
  assign vu_slow = (smp.up_speed < fes_pkg::LANDED_SPEED) &&
                   (smp.up_speed > -fes_pkg::LANDED_SPEED);

  assign h_gt_apogee = smp.height > $signed({1'b0, cfg.min_apogee_height});
  assign h_lt_main   = smp.height < $signed({1'b0, cfg.main_fire_height});
  assign h_gt_limit  = smp.height > $signed({1'b0, cfg.limit_height});

  assign burn_hold   = (smp.time_ms - bs_r) > fes_pkg::BURNOUT_HOLD_MS;
  assign desc_hold   = (smp.time_ms - ds_r) > fes_pkg::APOGEE_HOLD_MS;
  assign drogue_hold = (smp.time_ms - at_r) > fes_pkg::DROGUE_DELAY_MS;

  // landing site distance; launch height cannot change in a step that lands
  assign diff  = {smp.height[fes_pkg::HgtW-1], smp.height} - {lh_r[fes_pkg::HgtW-1], lh_r};
  assign gap   = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign gap20 = {1'b0, gap, 4'b0} + {3'b0, gap, 2'b0};
  always_comb begin
    if (lh_r[fes_pkg::HgtW-1]) begin
      near = 1'b1;
    end else if (lh_r == '0) begin
      near = 1'b0;
    end else begin
      near = gap20 < NW'(lh_r);
    end
  end

  assign speed_sq = {1'b0, sq.sq_east} + {1'b0, sq.sq_north} + {1'b0, sq.sq_up};
  assign speed_gt_limit = speed_sq > {2'b0, limit_sq};

  always_comb begin
    f       = flags_r;
    ev      = '0;
    bt_nxt  = bt_r;
    bs_nxt  = bs_r;
    dt_nxt  = dt_r;
    ds_nxt  = ds_r;
    atk_nxt = atk_r;
    at_nxt  = at_r;
    lh_nxt  = lh_r;

    if (!f[fes_pkg::FLG_LAUNCH] && acc_gt_launch) begin
      f[fes_pkg::FLG_LAUNCH]  = 1'b1;
      ev[fes_pkg::FLG_LAUNCH] = 1'b1;
      lh_nxt = smp.site_height;
    end

    if (f[fes_pkg::FLG_LAUNCH] && !f[fes_pkg::FLG_BURNOUT]) begin
      if (acc_lt_burnout && vu_pos) begin
        if (!bt_r) begin
          bt_nxt = 1'b1;
          bs_nxt = smp.time_ms;
        end else if (burn_hold) begin
          f[fes_pkg::FLG_BURNOUT]  = 1'b1;
          ev[fes_pkg::FLG_BURNOUT] = 1'b1;
        end
      end else begin
        bt_nxt = 1'b0;
      end
    end

    if (f[fes_pkg::FLG_LAUNCH] && f[fes_pkg::FLG_BURNOUT] && !f[fes_pkg::FLG_APOGEE]) begin
      if (vu_neg) begin
        if (!dt_r) begin
          dt_nxt = 1'b1;
          ds_nxt = smp.time_ms;
        end else if (desc_hold && h_gt_apogee) begin
          f[fes_pkg::FLG_APOGEE]  = 1'b1;
          ev[fes_pkg::FLG_APOGEE] = 1'b1;
        end
      end else begin
        dt_nxt = 1'b0;
      end
    end

    if ((f[2:0] == pre) && !f[fes_pkg::FLG_DROGUE]) begin
      if (!atk_r) begin
        atk_nxt = 1'b1;
        at_nxt  = smp.time_ms;
      end else if (drogue_hold) begin
        f[fes_pkg::FLG_DROGUE]  = 1'b1;
        ev[fes_pkg::FLG_DROGUE] = 1'b1;
      end
    end

    if ((f[2:0] == pre) && !f[fes_pkg::FLG_MAIN] && h_lt_main && vu_neg) begin
      f[fes_pkg::FLG_MAIN]  = 1'b1;
      ev[fes_pkg::FLG_MAIN] = 1'b1;
    end

    if ((f[2:0] == pre) && f[fes_pkg::FLG_DROGUE] && f[fes_pkg::FLG_MAIN] &&
        !f[fes_pkg::FLG_LANDED] && vu_slow && near) begin
      f[fes_pkg::FLG_LANDED]  = 1'b1;
      ev[fes_pkg::FLG_LANDED] = 1'b1;
    end

    if ((f[2:0] == pre) && !f[fes_pkg::FLG_DSEEN] && acc_gt_dspike) begin
      f[fes_pkg::FLG_DSEEN]  = 1'b1;
      ev[fes_pkg::FLG_DSEEN] = 1'b1;
    end

    if ((f[2:0] == pre) && f[fes_pkg::FLG_DROGUE] && !f[fes_pkg::FLG_MSEEN] &&
        acc_gt_mspike) begin
      f[fes_pkg::FLG_MSEEN]  = 1'b1;
      ev[fes_pkg::FLG_MSEEN] = 1'b1;
    end

    ev[fes_pkg::EV_LIMIT] = h_gt_limit || speed_gt_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      bt_r    <= 1'b0;
      bs_r    <= '0;
      dt_r    <= 1'b0;
      ds_r    <= '0;
      atk_r   <= 1'b0;
      at_r    <= '0;
      lh_r    <= '0;
    end else if (ld) begin
      flags_r <= f;
      bt_r    <= bt_nxt;
      bs_r    <= bs_nxt;
      dt_r    <= dt_nxt;
      ds_r    <= ds_nxt;
      atk_r   <= atk_nxt;
      at_r    <= at_nxt;
      lh_r    <= lh_nxt;
    end
  end

  assign events    = ev;
  assign flags_nxt = f;

`ifndef SYNTHESIS
  // latched flags never clear
  a_flags_latch: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((flags_r & $past(flags_r)) == $past(flags_r)))
    else $error("latched flight flag cleared");

  a_apogee_order: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[fes_pkg::FLG_APOGEE] |->
      (flags_r[fes_pkg::FLG_BURNOUT] && flags_r[fes_pkg::FLG_LAUNCH]))
    else $error("apogee latched before launch and burnout");

  a_apogee_timed: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ev[fes_pkg::FLG_APOGEE]) |-> dt_r)
    else $error("apogee raised without a running descent timer");
`endif

endmodule
